### rtl/pooled_bitmap_id_allocator_top_defines.svh
// Assertion macros for the pooled bitmap ID allocator.
`ifndef POOLED_BITMAP_ID_ALLOCATOR_TOP_DEFINES_SVH
`define POOLED_BITMAP_ID_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PBA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBA_ASSERT_IMPL(name, ante, cons, msg)
`define PBA_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### rtl/pba_pkg.sv
// Shared types and constants of the pooled bitmap ID allocator.
package pba_pkg;

    localparam int WORD_BITS   = 32;
    localparam int BIT_SHIFT   = 5;
    localparam int MAX_IDS_DEF = 1024;
    localparam int POOLS_DEF   = 3;

    localparam int NT_W        = 11;
    localparam int TID_W       = 32;
    localparam int POOL_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [NT_W-1:0]  ID_LIMIT_RST = 11'd1024;
    localparam logic [TID_W-1:0] ID_BASE_RST  = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLAIM   = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_FREE = 2'd1,
        STS_RANGE   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 scan;
        logic                 tail;
        logic [BIT_SHIFT-1:0] lim_lo;
        logic [BIT_SHIFT-1:0] bit_sel;
        logic                 set;
    } wu_req_t;

    typedef struct packed {
        logic                 hit;
        logic [BIT_SHIFT-1:0] pos;
        logic [WORD_BITS-1:0] new_word;
    } wu_rsp_t;

    typedef struct packed {
        status_t              status;
        logic [TID_W-1:0]     result_id;
        logic                 was_free;
    } result_t;

endpackage

### rtl/pba_map_ram.sv
// Free bitmap storage: one write port, one registered read port.
module pba_map_ram #(
    parameter int DEPTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [pba_pkg::WORD_BITS-1:0]  wdata,
    input  logic [AW-1:0]                  raddr,
    output logic [pba_pkg::WORD_BITS-1:0]  rdata
);

    logic [pba_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [pba_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pba_word_unit.sv
// Shared word unit: masked find-first-set or single-bit test, plus bit set/clear.
module pba_word_unit (
    input  pba_pkg::wu_req_t req,
    output pba_pkg::wu_rsp_t rsp
);

    logic [pba_pkg::WORD_BITS-1:0] tail_mask;
    logic [pba_pkg::WORD_BITS-1:0] scan_word;
    logic [pba_pkg::WORD_BITS-1:0] sel_bit;
    logic [pba_pkg::BIT_SHIFT-1:0] first_pos;
    logic [pba_pkg::BIT_SHIFT-1:0] pos;

    always_comb
    begin
        if (req.tail && (req.lim_lo != '0))
        begin
            tail_mask = (pba_pkg::WORD_BITS'(1) << req.lim_lo) - pba_pkg::WORD_BITS'(1);
        end
        else
        begin
            tail_mask = '1;
        end
        scan_word = req.word & tail_mask;
        first_pos = '0;
        for (int b = pba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (scan_word[b])
            begin
                first_pos = pba_pkg::BIT_SHIFT'(b);
            end
        end
    end

    always_comb
    begin
        pos          = req.scan ? first_pos : req.bit_sel;
        sel_bit      = pba_pkg::WORD_BITS'(1) << pos;
        rsp.pos      = pos;
        rsp.hit      = req.scan ? (|scan_word) : req.word[req.bit_sel];
        rsp.new_word = req.set ? (req.word | sel_bit) : (req.word & ~sel_bit);
    end

endmodule

### rtl/pba_seq.sv
// Sequencer: clearing pass, word scan for allocate, read-modify-write for release and claim, read and test for query.
module pba_seq #(
    parameter int MAX_IDS = pba_pkg::MAX_IDS_DEF,
    parameter int POOLS   = pba_pkg::POOLS_DEF,
    localparam int PW    = (MAX_IDS + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS,
    localparam int DEPTH = POOLS * PW,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int WW    = (PW > 1) ? $clog2(PW) : 1,
    localparam int IW    = WW + pba_pkg::BIT_SHIFT,
    localparam int LW    = $clog2(MAX_IDS + 1),
    localparam int CW    = (LW > pba_pkg::NT_W) ? LW : pba_pkg::NT_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pba_pkg::opcode_t               in_op,
    input  logic [pba_pkg::POOL_W-1:0]     in_pool,
    input  logic [pba_pkg::TID_W-1:0]      in_tid,
    input  logic [pba_pkg::NT_W-1:0]       id_limit,
    input  logic [pba_pkg::TID_W-1:0]      id_base,
    output logic                           res_valid,
    input  logic                           res_take,
    output pba_pkg::result_t               res,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [pba_pkg::WORD_BITS-1:0]  ram_wdata,
    output logic [AW-1:0]                  ram_raddr,
    input  logic [pba_pkg::WORD_BITS-1:0]  ram_rdata,
    output pba_pkg::wu_req_t               wu_req,
    input  pba_pkg::wu_rsp_t               wu_rsp
);

    pba_pkg::state_t             state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    pba_pkg::opcode_t            op_reg, op_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [pba_pkg::TID_W-1:0]   tid_reg, tid_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [WW-1:0]               w_reg, w_next;
    logic [WW-1:0]               chk_reg, chk_next;
    logic                        issue_reg, issue_next;
    logic                        chk_valid_reg, chk_valid_next;
    pba_pkg::result_t            res_reg, res_next;

    logic [CW-1:0]               lim_full;
    logic [LW-1:0]               lim;
    logic [LW-1:0]               lim_m1;
    logic [WW-1:0]               last_w;
    logic [pba_pkg::TID_W-1:0]   in_idx;
    logic                        in_range;
    logic [pba_pkg::POOL_W-1:0]  pool_sat;
    logic [AW-1:0]               in_base;
    logic                        lim_zero;
    logic                        scan_end;

    always_comb
    begin
        lim_full = (CW'(id_limit) > CW'(MAX_IDS)) ? CW'(MAX_IDS) : CW'(id_limit);
        lim      = lim_full[LW-1:0];
        lim_m1   = lim - LW'(1);
        last_w   = lim_m1[IW-1:pba_pkg::BIT_SHIFT];
        lim_zero = (lim == '0);
        in_idx   = in_tid - id_base;
        in_range = in_idx < pba_pkg::TID_W'(lim);
        pool_sat = (in_pool >= pba_pkg::POOL_W'(POOLS)) ? pba_pkg::POOL_W'(POOLS - 1) : in_pool;
        in_base  = AW'(pool_sat) * AW'(PW);
        scan_end = chk_valid_reg && (wu_rsp.hit || (chk_reg == last_w));
    end

    always_comb
    begin
        wu_req.word    = ram_rdata;
        wu_req.scan    = (state_reg == pba_pkg::S_SCAN);
        wu_req.tail    = (chk_reg == last_w);
        wu_req.lim_lo  = lim[pba_pkg::BIT_SHIFT-1:0];
        wu_req.bit_sel = idx_reg[pba_pkg::BIT_SHIFT-1:0];
        wu_req.set     = (op_reg == pba_pkg::OP_RELEASE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pba_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == pba_pkg::OP_ALLOC)
                    begin
                        state_next = lim_zero ? pba_pkg::S_DONE : pba_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = in_range ? pba_pkg::S_READ : pba_pkg::S_DONE;
                    end
                end
            end
            pba_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = pba_pkg::S_DONE;
                end
            end
            pba_pkg::S_READ:   state_next = pba_pkg::S_MODIFY;
            pba_pkg::S_MODIFY: state_next = pba_pkg::S_DONE;
            pba_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = pba_pkg::S_IDLE;
                end
            end
            default:           state_next = pba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next       = clr_reg;
        op_next        = op_reg;
        base_next      = base_reg;
        tid_next       = tid_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        chk_next       = chk_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = base_reg + AW'(chk_reg);
        ram_wdata      = wu_rsp.new_word;
        ram_raddr      = base_reg + AW'(w_reg);
        unique case (state_reg)
            pba_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
                clr_next  = clr_reg + AW'(1);
            end
            pba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next        = in_op;
                    base_next      = in_base;
                    tid_next       = in_tid;
                    idx_next       = in_idx[IW-1:0];
                    w_next         = '0;
                    issue_next     = 1'b1;
                    chk_valid_next = 1'b0;
                    res_next.result_id = in_tid;
                    res_next.was_free  = 1'b0;
                    res_next.status    = (in_op == pba_pkg::OP_ALLOC) ?
                                         pba_pkg::STS_NO_FREE : pba_pkg::STS_RANGE;
                end
            end
            pba_pkg::S_SCAN:
            begin
                chk_next       = w_reg;
                chk_valid_next = issue_reg;
                if (issue_reg)
                begin
                    if (w_reg == last_w)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        w_next = w_reg + WW'(1);
                    end
                end
                if (chk_valid_reg && wu_rsp.hit)
                begin
                    ram_we             = 1'b1;
                    res_next.status    = pba_pkg::STS_OK;
                    res_next.result_id = id_base
                                         + pba_pkg::TID_W'({chk_reg, wu_rsp.pos});
                    res_next.was_free  = 1'b1;
                end
                else if (chk_valid_reg && (chk_reg == last_w))
                begin
                    res_next.status    = pba_pkg::STS_NO_FREE;
                    res_next.result_id = tid_reg;
                    res_next.was_free  = 1'b0;
                end
            end
            pba_pkg::S_READ:
            begin
                ram_raddr = base_reg + AW'(idx_reg[IW-1:pba_pkg::BIT_SHIFT]);
            end
            pba_pkg::S_MODIFY:
            begin
                ram_we             = (op_reg != pba_pkg::OP_QUERY);
                ram_waddr          = base_reg + AW'(idx_reg[IW-1:pba_pkg::BIT_SHIFT]);
                res_next.status    = pba_pkg::STS_OK;
                res_next.result_id = tid_reg;
                res_next.was_free  = wu_rsp.hit;
            end
            pba_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pba_pkg::S_CLEAR;
            clr_reg       <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        base_reg <= base_next;
        tid_reg  <= tid_next;
        idx_reg  <= idx_next;
        w_reg    <= w_next;
        chk_reg  <= chk_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/pooled_bitmap_id_allocator_top.sv
// Top level of the pooled bitmap ID allocator: config registers, result register.
//
//   port group  dir  contents
//   s_*         in   request: opcode, pool, table_id
//   m_*         out  result: status, result_id, was_free
//   cfg_*       in   register write: 0 ID limit, 1 ID base
//
// After reset a clearing pass sets every bitmap word to all ones:
// all POOLS * ceil(MAX_IDS/32) words (96 by default) in turn, with s_tready low.
// Allocate: scans the pool's bitmap words in order, up to ceil(limit/32) words, until a free
// bit is found, reading the words through the single RAM read port.
// Release, claim, query: read, test, write back (not query); out of range or allocate with limit 0: skip the RAM.
// One request in flight; a result blocked by m_tready low holds s_tready low.
`include "pooled_bitmap_id_allocator_top_defines.svh"

module pooled_bitmap_id_allocator_top #(
    parameter int MAX_IDS = pba_pkg::MAX_IDS_DEF,
    parameter int POOLS   = pba_pkg::POOLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] opcode, [3:2] pool, [35:4] table_id, [39:36] zero
    input  logic [pba_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [33:2] result_id, [34] was_free, [39:35] zero
    output logic [pba_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pba_pkg::TID_W-1:0]        cfg_data
);

    localparam int PW    = (MAX_IDS + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
    localparam int DEPTH = POOLS * PW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OUT_PAD = pba_pkg::OUT_TDATA_W - pba_pkg::TID_W - 3;

    logic [pba_pkg::NT_W-1:0]      id_limit_reg;
    logic [pba_pkg::TID_W-1:0]     id_base_reg;
    logic                          m_tvalid_reg;
    pba_pkg::result_t              out_res_reg;

    logic                          res_valid;
    logic                          res_take;
    pba_pkg::result_t              res;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [pba_pkg::WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [pba_pkg::WORD_BITS-1:0] ram_rdata;
    pba_pkg::wu_req_t              wu_req;
    pba_pkg::wu_rsp_t              wu_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_limit_reg <= pba_pkg::ID_LIMIT_RST;
            id_base_reg  <= pba_pkg::ID_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pba_pkg::CFG_ID_LIMIT: id_limit_reg <= cfg_data[pba_pkg::NT_W-1:0];
                pba_pkg::CFG_ID_BASE:  id_base_reg  <= cfg_data;
                default:               id_base_reg  <= id_base_reg;
            endcase
        end
    end

    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {OUT_PAD'(0), out_res_reg.was_free, out_res_reg.result_id,
                       out_res_reg.status};

    pba_seq #(
        .MAX_IDS (MAX_IDS),
        .POOLS   (POOLS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (pba_pkg::opcode_t'(s_tdata[1:0])),
        .in_pool      (s_tdata[3:2]),
        .in_tid       (s_tdata[35:4]),
        .id_limit     (id_limit_reg),
        .id_base      (id_base_reg),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .wu_req       (wu_req),
        .wu_rsp       (wu_rsp)
    );

    pba_word_unit u_word_unit (
        .req (wu_req),
        .rsp (wu_rsp)
    );

    pba_map_ram #(
        .DEPTH (DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `PBA_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "ready after request")
    `PBA_ASSERT_IMPL(a_status_legal, m_tvalid_reg, (out_res_reg.status == pba_pkg::STS_OK) || (out_res_reg.status == pba_pkg::STS_NO_FREE) || (out_res_reg.status == pba_pkg::STS_RANGE), "bad status code")
    `PBA_ASSERT_IMPL(a_fail_not_free, m_tvalid_reg && (out_res_reg.status != pba_pkg::STS_OK), !out_res_reg.was_free, "failed request marked free")

endmodule

### tb/id_alloc_checker.sv
// Checker for the pooled bitmap ID allocator: tracks the free bitmaps and compares each result.
module id_alloc_checker #(
    parameter int MAX_IDS = pba_pkg::MAX_IDS_DEF,
    parameter int POOLS   = pba_pkg::POOLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // [1:0] opcode, [3:2] pool, [35:4] table_id, [39:36] zero
    input  logic [pba_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [33:2] result_id, [34] was_free, [39:35] zero
    input  logic [pba_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pba_pkg::TID_W-1:0]        cfg_data,
    output int                               fail_count,
    output int                               outstanding
);

    logic [MAX_IDS-1:0]            free_bits [POOLS];
    logic [pba_pkg::NT_W-1:0]      id_limit_q;
    logic [pba_pkg::TID_W-1:0]     offset_q;
    pba_pkg::result_t              pending_results [$];

    function automatic pba_pkg::result_t apply_request(pba_pkg::opcode_t op,
                                                       logic [pba_pkg::POOL_W-1:0] pool_sel,
                                                       logic [pba_pkg::TID_W-1:0] tid);
        pba_pkg::result_t          res;
        int                        p;
        int                        i;
        int                        slot;
        bit                        found;
        logic [pba_pkg::TID_W-1:0] lim;
        logic [pba_pkg::TID_W-1:0] idx;

        p     = (int'(pool_sel) >= POOLS) ? POOLS - 1 : int'(pool_sel);
        lim   = (id_limit_q > MAX_IDS) ? pba_pkg::TID_W'(MAX_IDS)
                                       : pba_pkg::TID_W'(id_limit_q);
        res.status    = pba_pkg::STS_OK;
        res.result_id = tid;
        res.was_free  = 1'b0;
        found = 1'b0;
        slot  = 0;
        if (op == pba_pkg::OP_ALLOC)
        begin
            for (i = 0; i < int'(lim); i++)
            begin
                if (!found && free_bits[p][i])
                begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found)
            begin
                free_bits[p][slot] = 1'b0;
                res.result_id      = offset_q + pba_pkg::TID_W'(slot);
                res.was_free       = 1'b1;
            end
            else
                res.status = pba_pkg::STS_NO_FREE;
        end
        else
        begin
            idx = tid - offset_q;
            if (idx >= lim)
                res.status = pba_pkg::STS_RANGE;
            else
            begin
                res.was_free = free_bits[p][idx];
                if (op == pba_pkg::OP_RELEASE)
                    free_bits[p][idx] = 1'b1;
                else if (op == pba_pkg::OP_CLAIM)
                    free_bits[p][idx] = 1'b0;
            end
        end
        return res;
    endfunction

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        pba_pkg::result_t want;
        int               p;

        if (!rst_n)
        begin
            for (p = 0; p < POOLS; p++)
                free_bits[p] = '1;
            id_limit_q = pba_pkg::ID_LIMIT_RST;
            offset_q   = pba_pkg::ID_BASE_RST;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pba_pkg::CFG_ID_LIMIT)
                    id_limit_q = cfg_data[pba_pkg::NT_W-1:0];
                else if (cfg_index == pba_pkg::CFG_ID_BASE)
                    offset_q = cfg_data;
            end
            // results leave before the request of the same edge can have one
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[33:2] !== want.result_id)
                    begin
                        $error("result_id: expected %h, got %h", want.result_id, m_tdata[33:2]);
                        fail_count++;
                    end
                    if (m_tdata[34] !== want.was_free)
                    begin
                        $error("was_free: expected %0d, got %0d", want.was_free, m_tdata[34]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_request(pba_pkg::opcode_t'(s_tdata[1:0]),
                                                        s_tdata[3:2], s_tdata[35:4]));
            outstanding <= pending_results.size();
        end
    end

endmodule

### tb/tb.sv
// Testbench top for the pooled bitmap ID allocator: clock, reset, requests and verdict.
module tb;

    localparam int MAX_IDS      = pba_pkg::MAX_IDS_DEF;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SEGMENTS     = 8;
    localparam int SEG_REQUESTS = 144;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [pba_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [pba_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_we;
    logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [pba_pkg::TID_W-1:0]       cfg_data;

    int                        fail_count;
    int                        outstanding;
    int                        quiet_cycles;
    int                        send_idle_pct;
    int                        recv_stall_pct;
    logic [pba_pkg::NT_W-1:0]  cur_num;
    logic [pba_pkg::TID_W-1:0] cur_off;

    int unsigned               seg_num [SEGMENTS] = '{1024, 40, 2047, 7, 300, 33, 1, 1024};
    logic [pba_pkg::TID_W-1:0] seg_off [SEGMENTS] = '{32'h0, 32'h0, 32'hFFFF_FFF8, 32'h0,
                                                       32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                                                       32'h20};

    pooled_bitmap_id_allocator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    id_alloc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(pba_pkg::opcode_t op, logic [pba_pkg::POOL_W-1:0] pool_sel,
                                logic [pba_pkg::TID_W-1:0] tid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, tid, pool_sel, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_config(logic [pba_pkg::NT_W-1:0] num, logic [pba_pkg::TID_W-1:0] off);
        cfg_we    <= 1'b1;
        cfg_index <= pba_pkg::CFG_ID_LIMIT;
        cfg_data  <= pba_pkg::TID_W'(num);
        @(posedge clk);
        cfg_index <= pba_pkg::CFG_ID_BASE;
        cfg_data  <= off;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_num = num;
        cur_off = off;
    endtask

    task automatic random_request();
        int unsigned               lim;
        int unsigned               pick;
        pba_pkg::opcode_t          op;
        logic [pba_pkg::TID_W-1:0] tid;

        lim  = (cur_num > MAX_IDS) ? MAX_IDS : cur_num;
        pick = $urandom_range(99);
        op   = (pick < 35) ? pba_pkg::OP_ALLOC :
               (pick < 65) ? pba_pkg::OP_RELEASE :
               (pick < 80) ? pba_pkg::OP_CLAIM : pba_pkg::OP_QUERY;
        pick = $urandom_range(99);
        if (pick < 85 && lim != 0)
            tid = cur_off + pba_pkg::TID_W'($urandom_range(lim - 1));
        else if (pick < 95)
            tid = $urandom_range(1) ? cur_off + lim + pba_pkg::TID_W'($urandom_range(2))
                                    : cur_off - 1 - pba_pkg::TID_W'($urandom_range(1));
        else
            tid = $urandom;
        send_request(op, pba_pkg::POOL_W'($urandom_range(3)), tid);
    endtask

    initial
    begin
        int seg;
        int n;

        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = pba_pkg::CFG_ID_LIMIT;
        cfg_data       = '0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_num        = pba_pkg::ID_LIMIT_RST;
        cur_off        = pba_pkg::ID_BASE_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 1024 IDs from 0
        send_request(pba_pkg::OP_QUERY, 2'd0, 32'd0);
        send_request(pba_pkg::OP_ALLOC, 2'd0, 32'hDEAD_BEEF);
        send_request(pba_pkg::OP_ALLOC, 2'd0, 32'd0);
        send_request(pba_pkg::OP_CLAIM, 2'd0, 32'd1);
        send_request(pba_pkg::OP_CLAIM, 2'd1, 32'd5);
        send_request(pba_pkg::OP_RELEASE, 2'd0, 32'd1);
        send_request(pba_pkg::OP_RELEASE, 2'd0, 32'd1);
        send_request(pba_pkg::OP_QUERY, 2'd2, 32'd1023);
        send_request(pba_pkg::OP_QUERY, 2'd2, 32'd1024);
        send_request(pba_pkg::OP_RELEASE, 2'd1, 32'hFFFF_FFFF);
        send_request(pba_pkg::OP_CLAIM, 2'd0, 32'd1024);
        send_request(pba_pkg::OP_ALLOC, 2'd3, 32'd0);
        send_request(pba_pkg::OP_QUERY, 2'd2, 32'd0);
        send_request(pba_pkg::OP_ALLOC, 2'd1, 32'd0);
        drain();
        set_config(11'd0, 32'h0);
        send_request(pba_pkg::OP_ALLOC, 2'd0, 32'h5555_5555);
        send_request(pba_pkg::OP_QUERY, 2'd0, 32'd0);
        drain();
        // three IDs, offset wraps past zero; pool 0 runs dry
        set_config(11'd3, 32'hFFFF_FFFF);
        send_request(pba_pkg::OP_ALLOC, 2'd0, 32'd0);
        send_request(pba_pkg::OP_ALLOC, 2'd0, 32'd0);
        send_request(pba_pkg::OP_ALLOC, 2'd0, 32'hAAAA_AAAA);
        send_request(pba_pkg::OP_QUERY, 2'd0, 32'hFFFF_FFFF);
        send_request(pba_pkg::OP_QUERY, 2'd0, 32'd2);
        drain();
        set_config(11'd1, 32'hFFFF_FFFF);
        send_request(pba_pkg::OP_RELEASE, 2'd0, 32'd0);
        drain();
        set_config(11'd2047, 32'h0);
        send_request(pba_pkg::OP_QUERY, 2'd0, 32'd1);
        send_request(pba_pkg::OP_QUERY, 2'd0, 32'd1024);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            send_idle_pct  = (seg == 2 || seg == 3) ? 69 : (seg >= 6) ? 30 : 0;
            recv_stall_pct = (seg == 4 || seg == 5) ? 69 : (seg >= 6) ? 30 : 0;
            set_config(pba_pkg::NT_W'(seg_num[seg]),
                       (seg % 3 == 1) ? pba_pkg::TID_W'($urandom) : seg_off[seg]);
            for (n = 0; n < SEG_REQUESTS; n++)
                random_request();
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
